>>> hw/rtl/sdpts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdpts_pkg;

    localparam int DATA_W    = 16;
    localparam int MAX_TERMS = 256;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int CFG_W     = 4;
    localparam int IDX_W     = 2;
    localparam int LVL_W     = CFG_W + 1;
    localparam int PC_W      = 3;

    localparam logic [IDX_W-1:0] REG_SHIFT_A        = 2'd0;
    localparam logic [IDX_W-1:0] REG_SHIFT_B        = 2'd1;
    localparam logic [IDX_W-1:0] REG_HALVING_LEVELS = 2'd2;
    localparam logic [IDX_W-1:0] REG_PLAIN_LEVELS   = 2'd3;

    typedef logic [PC_W-1:0] upc_t;

    // microprogram addresses
    localparam upc_t UP_IDLE  = 3'd0;
    localparam upc_t UP_STORE = 3'd1;
    localparam upc_t UP_CHECK = 3'd2;
    localparam upc_t UP_READ  = 3'd3;
    localparam upc_t UP_SUM   = 3'd4;
    localparam upc_t UP_NEXT  = 3'd5;
    localparam upc_t UP_FIN   = 3'd6;
    localparam upc_t UP_OUT   = 3'd7;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_NOT_LAST,
        C_LEVELS_DONE,
        C_MORE_ELEM,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  st_prod;
        logic  rd_pair;
        logic  rd_zero;
        logic  wr_tree;
        logic  nxt_lvl;
        logic  ld_out;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // control store: jump to target when cond holds, else step on
    function automatic uword_t urom(input upc_t pc);
        uword_t w;
        w = '0;
        w.cond = C_NEVER;
        w.target = UP_IDLE;
        case (pc)
            UP_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = C_NO_ACCEPT;
                w.target  = UP_IDLE;
            end
            UP_STORE:
            begin
                w.st_prod = 1'b1;
                w.cond    = C_NOT_LAST;
                w.target  = UP_IDLE;
            end
            UP_CHECK:
            begin
                w.cond   = C_LEVELS_DONE;
                w.target = UP_FIN;
            end
            UP_READ:
            begin
                w.rd_pair = 1'b1;
            end
            UP_SUM:
            begin
                w.wr_tree = 1'b1;
                w.cond    = C_MORE_ELEM;
                w.target  = UP_READ;
            end
            UP_NEXT:
            begin
                w.nxt_lvl = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = UP_CHECK;
            end
            UP_FIN:
            begin
                w.rd_zero = 1'b1;
            end
            UP_OUT:
            begin
                // falls through to the idle step once the result is loaded
                w.ld_out = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = UP_OUT;
            end
            default:
            begin
                w.cond = C_NEVER;
            end
        endcase
        return w;
    endfunction

    // divide by 2^s, toward zero
    function automatic logic signed [DATA_W-1:0] scale_down(
        input logic signed [DATA_W-1:0] v,
        input logic [CFG_W-1:0]         s
    );
        logic [DATA_W-1:0]        mask;
        logic signed [DATA_W-1:0] t;
        mask = ~({DATA_W{1'b1}} << s);
        t = v;
        if (v[DATA_W-1])
        begin
            t = v + $signed(mask);
        end
        return t >>> s;
    endfunction

    // divide by two, toward zero
    function automatic logic signed [DATA_W-1:0] halve(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] t;
        t = v + $signed({{(DATA_W-1){1'b0}}, v[DATA_W-1]});
        return t >>> 1;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sdpts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sdpts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scaled_dot_product_tree_sum_core.sv
// Scaled dot product with pairwise tree reduction.
// Input channel (in_valid / in_stall) carries one operand pair per transaction,
// with last_pair closing the dot product. Each operand is scaled down by its
// configured power of two, the product is written to a 256-entry store, and
// on the last pair the store is reduced in place by the tree and entry zero
// is returned on the output channel (out_valid / out_stall) with the overflow
// flag. Pairs beyond capacity are dropped and set overflowed.
// Steps, all run by a microcoded sequencer over one two-read-port RAM:
//   non-last pair: capture, then multiply and store.
//   last pair: capture, store, then per level a check, a read and a sum step
//   per output entry and a level step, then a read of entry zero and the load;
//   the read and sum steps per tree element come from the registered RAM read.
// Config (cfg_write_en / cfg_index / cfg_data) must be written only while idle; not enforced.
// The result sits in an output register; the next dot product may load
// pairs while it waits, but a following result holds the sequencer until the
// receiver drops out_stall. in_stall is high in every step but the idle one.
// Reset clears config, counts and the drop flag, not store, dot_sum, overflowed.
`timescale 1ns / 1ps
`default_nettype none

module scaled_dot_product_tree_sum_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic        [sdpts_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic        [sdpts_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [sdpts_pkg::DATA_W-1:0]  a_value,
    input  wire logic signed [sdpts_pkg::DATA_W-1:0]  b_value,
    input  wire logic                                 last_pair,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed      [sdpts_pkg::DATA_W-1:0]  dot_sum,
    output logic                                      overflowed
);

    import sdpts_pkg::*;

    logic [CFG_W-1:0] shift_a_reg;
    logic [CFG_W-1:0] shift_b_reg;
    logic [CFG_W-1:0] halving_reg;
    logic [CFG_W-1:0] plain_reg;

    upc_t             pc_reg;
    upc_t             pc_next;
    logic [CNT_W-1:0] pair_count_reg;
    logic [CNT_W-1:0] pair_count_next;
    logic             drop_reg;
    logic             drop_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [LVL_W-1:0] lvl_reg;
    logic [LVL_W-1:0] lvl_next;
    logic [ADDR_W-1:0] p_reg;
    logic [ADDR_W-1:0] p_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] dot_sum_reg;
    logic                     overflowed_reg;

    uword_t           uw;
    logic             in_acc;
    logic             out_free;
    logic             jump;
    logic             full;
    logic             more_elem;
    logic             pair_ok;
    logic             halve_lvl;
    logic             load;
    logic [LVL_W-1:0] levels;
    logic [CNT_W-1:0] outs;

    logic signed [2*DATA_W-1:0] prod_full;
    logic signed [DATA_W-1:0]   tree_sum;
    logic signed [DATA_W-1:0]   tree_val;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr0;
    logic [ADDR_W-1:0] ram_raddr1;
    logic [DATA_W-1:0] ram_rdata0;
    logic [DATA_W-1:0] ram_rdata1;

    assign uw        = urom(pc_reg);
    assign in_stall  = !uw.take_in || !rst_n;
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = uw.ld_out && out_free;
    assign full      = (pair_count_reg == CNT_W'(MAX_TERMS));
    assign levels    = {1'b0, halving_reg} + {1'b0, plain_reg};
    assign outs      = CNT_W'(({1'b0, n_reg} + (CNT_W+1)'(1)) >> 1);
    assign more_elem = (CNT_W'(p_reg) + CNT_W'(1)) < outs;
    assign pair_ok   = (CNT_W+1)'({p_reg, 1'b1}) < (CNT_W+1)'(n_reg);
    assign halve_lvl = lvl_reg < {1'b0, halving_reg};

    assign prod_full = a_reg * b_reg;
    assign tree_sum  = pair_ok ? $signed(ram_rdata0 + ram_rdata1) : $signed(ram_rdata0);
    assign tree_val  = halve_lvl ? halve(tree_sum) : tree_sum;

    assign ram_we     = (uw.st_prod && !full) || uw.wr_tree;
    assign ram_waddr  = uw.wr_tree ? p_reg : pair_count_reg[ADDR_W-1:0];
    assign ram_wdata  = uw.wr_tree ? tree_val : prod_full[DATA_W-1:0];
    assign ram_re     = uw.rd_pair || uw.rd_zero;
    assign ram_raddr0 = uw.rd_zero ? '0 : {p_reg[ADDR_W-2:0], 1'b0};
    assign ram_raddr1 = {p_reg[ADDR_W-2:0], 1'b1};

    sdpts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TERMS)
    ) u_store (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    always_comb
    begin
        case (uw.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_ACCEPT:   jump = !in_acc;
            C_NOT_LAST:    jump = !last_reg;
            C_LEVELS_DONE: jump = lvl_reg >= levels;
            C_MORE_ELEM:   jump = more_elem;
            C_OUT_BUSY:    jump = !out_free;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next         = jump ? uw.target : pc_reg + upc_t'(1);
        pair_count_next = pair_count_reg;
        drop_next       = drop_reg;
        n_next          = n_reg;
        lvl_next        = lvl_reg;
        p_next          = p_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (uw.st_prod)
        begin
            if (full)
            begin
                drop_next = 1'b1;
                n_next    = pair_count_reg;
            end
            else
            begin
                pair_count_next = pair_count_reg + CNT_W'(1);
                n_next          = pair_count_reg + CNT_W'(1);
            end
            lvl_next = '0;
            p_next   = '0;
        end

        if (uw.wr_tree && more_elem)
        begin
            p_next = p_reg + ADDR_W'(1);
        end

        if (uw.nxt_lvl)
        begin
            n_next   = outs;
            lvl_next = lvl_reg + LVL_W'(1);
            p_next   = '0;
        end

        if (load)
        begin
            out_valid_next  = 1'b1;
            pair_count_next = '0;
            drop_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= UP_IDLE;
            pair_count_reg <= '0;
            drop_reg       <= 1'b0;
            n_reg          <= '0;
            lvl_reg        <= '0;
            p_reg          <= '0;
            out_valid_reg  <= 1'b0;
            shift_a_reg    <= '0;
            shift_b_reg    <= '0;
            halving_reg    <= '0;
            plain_reg      <= '0;
        end
        else
        begin
            pc_reg         <= pc_next;
            pair_count_reg <= pair_count_next;
            drop_reg       <= drop_next;
            n_reg          <= n_next;
            lvl_reg        <= lvl_next;
            p_reg          <= p_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SHIFT_A:        shift_a_reg <= cfg_data;
                    REG_SHIFT_B:        shift_b_reg <= cfg_data;
                    REG_HALVING_LEVELS: halving_reg <= cfg_data;
                    REG_PLAIN_LEVELS:   plain_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_reg    <= scale_down(a_value, shift_a_reg);
            b_reg    <= scale_down(b_value, shift_b_reg);
            last_reg <= last_pair;
        end
        if (load)
        begin
            dot_sum_reg    <= $signed(ram_rdata0);
            overflowed_reg <= drop_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dot_sum    = dot_sum_reg;
    assign overflowed = overflowed_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pair_count_reg <= CNT_W'(MAX_TERMS))
        else $error("pair count beyond store capacity");

    a_tree_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        uw.wr_tree |-> (CNT_W'(p_reg) < outs))
        else $error("tree write past the level's outputs");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pair_count_reg == '0) && !drop_reg && out_valid_reg)
        else $error("result load did not restart the dot product");

    a_accept_then_store: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (pc_reg == UP_STORE))
        else $error("accepted pair not followed by the store step");
`endif

endmodule

`default_nettype wire
